/* rtl/core/etl_pkg.sv */
// ----------------------------------------------------------------------------
// etl_pkg: shared types and constants of the expression token lexer
// Item and token layouts, token/operator/error codes, character codes and
// sizing of the token queue.
// ----------------------------------------------------------------------------
package etl_pkg;

  localparam logic [7:0] MAX_CHARS       = 8'd149;
  localparam logic [3:0] MAX_FRAC_DIGITS = 4'd9;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Token kinds
  localparam logic [2:0] KIND_NUM = 3'd0;
  localparam logic [2:0] KIND_LB  = 3'd1;
  localparam logic [2:0] KIND_RB  = 3'd2;
  localparam logic [2:0] KIND_OP  = 3'd3;
  localparam logic [2:0] KIND_ERR = 3'd4;

  // Operator codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;
  localparam logic [2:0] OP_LOG = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_POINT   = 2'd1;
  localparam logic [1:0] ERR_INVALID = 2'd2;
  localparam logic [1:0] ERR_LOG     = 2'd3;

  // Character codes
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_G      = 8'h67;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [2:0]  op_code;
    logic [7:0]  bracket_char;
    logic [30:0] int_part;
    logic        is_decimal;
    logic [29:0] frac_digits;
    logic [3:0]  frac_count;
    logic [1:0]  error_code;
    logic        last_of_run;
  } out_token_t;

  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       is_point;
    logic       is_lbr;
    logic       is_rbr;
    logic       is_ws;
    logic       is_op;
    logic [2:0] op;
    logic       is_l;
    logic       is_o;
    logic       is_g;
  } char_class_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_token_t tok0;
    out_token_t tok1;
  } fifo_wr_t;

endpackage

/* rtl/core/etl_classify.sv */
// ----------------------------------------------------------------------------
// etl_classify: character decoder
// Sorts one incoming character into the classes the lexer acts on.
// ----------------------------------------------------------------------------
module etl_classify (
  input  logic [7:0]           char_code,
  output etl_pkg::char_class_t cls
);
  import etl_pkg::*;

  always_comb begin
    cls = '0;
    cls.is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    cls.digit    = 4'(char_code - CH_ZERO);
    cls.is_point = (char_code == CH_POINT);
    cls.is_lbr   = (char_code == CH_LPAREN) || (char_code == CH_LBRACK) ||
                   (char_code == CH_LBRACE);
    cls.is_rbr   = (char_code == CH_RPAREN) || (char_code == CH_RBRACK) ||
                   (char_code == CH_RBRACE);
    cls.is_ws    = (char_code == CH_SPACE) ||
                   ((char_code >= CH_TAB) && (char_code <= CH_CR));
    cls.is_l     = (char_code == CH_L);
    cls.is_o     = (char_code == CH_O);
    cls.is_g     = (char_code == CH_G);
    cls.is_op    = 1'b1;
    case (char_code)
      CH_PLUS:  cls.op = OP_ADD;
      CH_MINUS: cls.op = OP_SUB;
      CH_STAR:  cls.op = OP_MUL;
      CH_SLASH: cls.op = OP_DIV;
      CH_CARET: cls.op = OP_POW;
      default: begin
        cls.op    = OP_ADD;
        cls.is_op = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/etl_lexer.sv */
// ----------------------------------------------------------------------------
// etl_lexer: token former
// Holds the scan state and number accumulators, and forms up to two tokens
// for each accepted character.
// ----------------------------------------------------------------------------
module etl_lexer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 end_of_expr,
  input  logic [7:0]           char_code,
  input  etl_pkg::char_class_t cls,
  output etl_pkg::fifo_wr_t    wr
);
  import etl_pkg::*;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_INT  = 3'd1;
  localparam logic [2:0] M_FRAC = 3'd2;
  localparam logic [2:0] M_L    = 3'd3;
  localparam logic [2:0] M_LO   = 3'd4;

  localparam logic [34:0] INT_SAT = 35'h7FFFFFFF;

  logic [2:0]  mode_r, mode_nxt;
  logic [30:0] int_r, int_nxt;
  logic [29:0] frac_r, frac_nxt;
  logic [3:0]  fcnt_r, fcnt_nxt;
  logic [7:0]  pos_r, pos_nxt;

  function automatic out_token_t mk_tok(input logic [2:0] kind, input logic [2:0] op,
                                        input logic [7:0] br, input logic [1:0] err);
    out_token_t t;
    t              = '0;
    t.token_kind   = kind;
    t.op_code      = op;
    t.bracket_char = br;
    t.error_code   = err;
    return t;
  endfunction

  function automatic out_token_t mk_num(input logic dec, input logic [30:0] ip,
                                        input logic [29:0] fd, input logic [3:0] fc);
    out_token_t t;
    t             = '0;
    t.token_kind  = KIND_NUM;
    t.int_part    = ip;
    t.is_decimal  = dec;
    t.frac_digits = dec ? fd : 30'd0;
    t.frac_count  = dec ? fc : 4'd0;
    return t;
  endfunction

  out_token_t  tk [2];
  logic [1:0]  n;
  logic        do_idle;
  logic [34:0] int_mul;
  logic [33:0] frac_mul;

  always_comb begin
    mode_nxt = mode_r;
    int_nxt  = int_r;
    frac_nxt = frac_r;
    fcnt_nxt = fcnt_r;
    pos_nxt  = pos_r;
    n        = 2'd0;
    tk[0]    = '0;
    tk[1]    = '0;
    do_idle  = 1'b0;
    int_mul  = ({4'd0, int_r} << 3) + ({4'd0, int_r} << 1) + {31'd0, cls.digit};
    frac_mul = ({4'd0, frac_r} << 3) + ({4'd0, frac_r} << 1) + {30'd0, cls.digit};

    if (pos_r < MAX_CHARS) begin
      pos_nxt = pos_r + 8'd1;
      case (mode_r)
        M_L: begin
          if (cls.is_o) begin
            mode_nxt = M_LO;
          end else begin
            mode_nxt = M_IDLE;
            tk[n[0]] = mk_tok(KIND_ERR, OP_ADD, 8'd0, ERR_LOG);
            n        = n + 2'd1;
          end
        end
        M_LO: begin
          mode_nxt = M_IDLE;
          if (cls.is_g) begin
            tk[n[0]] = mk_tok(KIND_OP, OP_LOG, 8'd0, ERR_NONE);
          end else begin
            tk[n[0]] = mk_tok(KIND_ERR, OP_ADD, 8'd0, ERR_LOG);
          end
          n = n + 2'd1;
        end
        M_INT, M_FRAC: begin
          if (cls.is_digit) begin
            if (mode_r == M_INT) begin
              int_nxt = (int_mul > INT_SAT) ? INT_SAT[30:0] : int_mul[30:0];
            end else if (fcnt_r < MAX_FRAC_DIGITS) begin
              frac_nxt = frac_mul[29:0];
              fcnt_nxt = fcnt_r + 4'd1;
            end
          end else if (cls.is_point) begin
            if (mode_r == M_INT) begin
              mode_nxt = M_FRAC;
            end else begin
              int_nxt  = '0;
              frac_nxt = '0;
              fcnt_nxt = '0;
              mode_nxt = M_IDLE;
              tk[n[0]] = mk_tok(KIND_ERR, OP_ADD, 8'd0, ERR_POINT);
              n        = n + 2'd1;
            end
          end else begin
            // The pending number goes out first, then the character is lexed afresh.
            tk[n[0]] = mk_num(mode_r == M_FRAC, int_r, frac_r, fcnt_r);
            n        = n + 2'd1;
            int_nxt  = '0;
            frac_nxt = '0;
            fcnt_nxt = '0;
            mode_nxt = M_IDLE;
            do_idle  = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
          do_idle  = 1'b1;
        end
      endcase

      if (do_idle) begin
        if (cls.is_digit) begin
          int_nxt  = {27'd0, cls.digit};
          frac_nxt = '0;
          fcnt_nxt = '0;
          mode_nxt = M_INT;
        end else if (cls.is_point) begin
          int_nxt  = '0;
          frac_nxt = '0;
          fcnt_nxt = '0;
          mode_nxt = M_FRAC;
        end else if (cls.is_lbr) begin
          tk[n[0]] = mk_tok(KIND_LB, OP_ADD, char_code, ERR_NONE);
          n        = n + 2'd1;
        end else if (cls.is_rbr) begin
          tk[n[0]] = mk_tok(KIND_RB, OP_ADD, char_code, ERR_NONE);
          n        = n + 2'd1;
        end else if (cls.is_ws) begin
          mode_nxt = M_IDLE;
        end else if (cls.is_op) begin
          tk[n[0]] = mk_tok(KIND_OP, cls.op, 8'd0, ERR_NONE);
          n        = n + 2'd1;
        end else if (cls.is_l) begin
          mode_nxt = M_L;
        end else begin
          tk[n[0]] = mk_tok(KIND_ERR, OP_ADD, 8'd0, ERR_INVALID);
          n        = n + 2'd1;
        end
      end
    end

    if (end_of_expr) begin
      if ((mode_nxt == M_INT) || (mode_nxt == M_FRAC)) begin
        tk[n[0]] = mk_num(mode_nxt == M_FRAC, int_nxt, frac_nxt, fcnt_nxt);
        n        = n + 2'd1;
      end else if ((mode_nxt == M_L) || (mode_nxt == M_LO)) begin
        tk[n[0]] = mk_tok(KIND_ERR, OP_ADD, 8'd0, ERR_LOG);
        n        = n + 2'd1;
      end
      mode_nxt = M_IDLE;
      int_nxt  = '0;
      frac_nxt = '0;
      fcnt_nxt = '0;
      pos_nxt  = '0;
    end

    if (n != 2'd0) begin
      tk[n == 2'd2].last_of_run = 1'b1;
    end

    wr.cnt  = accept ? n : 2'd0;
    wr.tok0 = tk[0];
    wr.tok1 = tk[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      int_r  <= '0;
      frac_r <= '0;
      fcnt_r <= '0;
      pos_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      int_r  <= int_nxt;
      frac_r <= frac_nxt;
      fcnt_r <= fcnt_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

/* rtl/core/etl_token_fifo.sv */
// ----------------------------------------------------------------------------
// etl_token_fifo: token queue
// Small queue that takes up to two tokens per beat and hands out one.
// ----------------------------------------------------------------------------
module etl_token_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  etl_pkg::fifo_wr_t          wr,
  input  logic                       pop,
  output logic                       empty,
  output logic                       full,
  output etl_pkg::out_token_t        rd_tok,
  output logic [etl_pkg::FIFO_CW-1:0] level
);
  import etl_pkg::*;

  out_token_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_r, wp_nxt;
  logic [FIFO_AW-1:0]   rp_r, rp_nxt;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;
  logic                 do_pop;

  assign empty  = (cnt_r == '0);
  // Room for two tokens is kept so that any item can be taken.
  assign full   = (cnt_r > FIFO_CW'(FIFO_DEPTH - 2));
  assign rd_tok = mem_r[rp_r];
  assign level  = cnt_r;
  assign do_pop = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r + FIFO_AW'(wr.cnt);
    rp_nxt  = rp_r + FIFO_AW'(do_pop);
    cnt_nxt = cnt_r + FIFO_CW'(wr.cnt) - FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) begin
      mem_r[wp_r] <= wr.tok0;
    end
    if (wr.cnt == 2'd2) begin
      mem_r[wp_r + FIFO_AW'(1)] <= wr.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/expression_token_lexer_core.sv */
// ----------------------------------------------------------------------------
// expression_token_lexer_core: expression character lexer
// Takes one character per beat and delivers number, bracket, operator and
// error tokens through a token queue.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the token queue is not full; the lexer state is registered.
// A token written by an accepted character is poppable in the next cycle.
// Up to two tokens per character; the output side drains one per cycle while pop is high and the queue is not empty.
// Reset (synchronous, rst_n low): scan state idle, accumulators and position
// cleared, token queue emptied.
module expression_token_lexer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  etl_pkg::in_item_t   in_item,
  output logic                empty,
  input  logic                pop,
  output etl_pkg::out_token_t out_token
);
  import etl_pkg::*;

  char_class_t        cls;
  fifo_wr_t           wr;
  logic               accept;
  logic [FIFO_CW-1:0] level;

  assign accept = push && !full;

  etl_classify u_classify (
    .char_code (in_item.char_code),
    .cls       (cls)
  );

  etl_lexer u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .end_of_expr (in_item.end_of_expr),
    .char_code   (in_item.char_code),
    .cls         (cls),
    .wr          (wr)
  );

  etl_token_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .pop    (pop),
    .empty  (empty),
    .full   (full),
    .rd_tok (out_token),
    .level  (level)
  );

  // The queue never holds more tokens than it has entries.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= FIFO_CW'(FIFO_DEPTH))
    else $error("token queue overfilled");

  // Only an accepted character writes tokens.
  a_write_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.cnt != 2'd0) |-> accept)
    else $error("tokens written without an accepted beat");

  // The final token of a character carries the run marker, and only it.
  a_last_marker_one: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.cnt == 2'd1) |-> wr.tok0.last_of_run)
    else $error("single token without run marker");

  a_last_marker_two: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.cnt == 2'd2) |-> (wr.tok1.last_of_run && !wr.tok0.last_of_run))
    else $error("token pair with misplaced run marker");

  // A token written into an empty queue is visible in the next cycle.
  a_visible_next: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.cnt != 2'd0) |=> !empty)
    else $error("written token not visible");

endmodule
